/* rtl/lcsr_pkg.sv */
// ----------------------------------------------------------------------------
// lcsr_pkg
// Shared types and constants for the load-cell serial reader.
// ----------------------------------------------------------------------------
`default_nettype none

package lcsr_pkg;

	// Converter timing and data format
	localparam int POLL_TICKS = 10;
	localparam int DATA_BITS  = 24;

	// Field widths
	localparam int RAW_W      = 24;
	localparam int GAIN_W     = 32;
	localparam int LIMIT_W    = 16;
	localparam int DB_W       = 23;
	localparam int WEIGHT_W   = 16;
	localparam int NET_W      = RAW_W + 2;
	localparam int POLL_W     = 16;
	localparam int DIV_W      = 4;
	localparam int BIT_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int PROD_W     = RAW_W + GAIN_W;
	localparam int SEXT_SH    = RAW_W - DATA_BITS;

	// Register reset values
	localparam logic signed [RAW_W-1:0] TARE_RST  = -24'sd600000;
	localparam logic [GAIN_W-1:0]       GAIN_RST  = 32'd858993;
	localparam logic [LIMIT_W-1:0]      LIMIT_RST = 16'd10000;
	localparam logic [DB_W-1:0]         DB_RST    = 23'd5000;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARE     = 2'd0,
		CFG_GAIN     = 2'd1,
		CFG_LIMIT    = 2'd2,
		CFG_DEADBAND = 2'd3
	} cfg_idx_t;

	// Current register values
	typedef struct packed {
		logic signed [RAW_W-1:0] tare;
		logic [GAIN_W-1:0]       gain;
		logic [LIMIT_W-1:0]      limit;
		logic [DB_W-1:0]         deadband;
	} cfg_t;

	// First stage result: pin levels, status and clamped net count
	typedef struct packed {
		logic                    clock_pin;
		logic                    busy;
		logic                    done;
		logic                    timed_out;
		logic signed [RAW_W-1:0] raw;
		logic [RAW_W-1:0]        net;
	} s1_t;

endpackage

`default_nettype wire

/* rtl/load_cell_serial_reader.sv */
// Each result beat is registered in stage 1, then in the output register.
// Throughput: one input beat per cycle when not stalled; the sequencer step
// and net count sit in stage 1, the gain multiply and saturation in stage 2.
// Output stalls hold both stages; input ready follows the output register.
// Reset (arst_n low): idle, counters and held raw/weight cleared, registers
// at their documented defaults. No clearing pass.
// ----------------------------------------------------------------------------
// load_cell_serial_reader
// Two-wire load-cell converter reader with tare, deadband and fixed gain.
// ----------------------------------------------------------------------------
`default_nettype none

module load_cell_serial_reader
	import lcsr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  start_req,
	input  wire logic                  data_pin,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       clock_pin,
	output logic                       busy_res,
	output logic                       done_res,
	output logic                       timed_out,
	output logic signed [RAW_W-1:0]    raw_count,
	output logic [WEIGHT_W-1:0]        weight_code,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic en, in_fire, v_s1;
	cfg_t cfg;
	s1_t  res_s1;

	// Pipeline advances whenever the output slot frees up
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	lcsr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	lcsr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_fire   (in_fire),
		.start_req (start_req),
		.data_pin  (data_pin),
		.cfg       (cfg),
		.v_s1      (v_s1),
		.res_s1    (res_s1)
	);

	lcsr_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.v_s1        (v_s1),
		.res_s1      (res_s1),
		.gain        (cfg.gain),
		.out_valid   (out_valid),
		.clock_pin   (clock_pin),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.timed_out   (timed_out),
		.raw_count   (raw_count),
		.weight_code (weight_code)
	);

endmodule

`default_nettype wire

/* rtl/lcsr_cfg.sv */
// ----------------------------------------------------------------------------
// lcsr_cfg
// Configuration register file: tare, gain, poll limit and zero deadband.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsr_cfg
	import lcsr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	// Register writes, one register per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tare     <= TARE_RST;
			cfg_q.gain     <= GAIN_RST;
			cfg_q.limit    <= LIMIT_RST;
			cfg_q.deadband <= DB_RST;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_TARE:     cfg_q.tare     <= $signed(wr_data[RAW_W-1:0]);
				CFG_GAIN:     cfg_q.gain     <= wr_data[GAIN_W-1:0];
				CFG_LIMIT:    cfg_q.limit    <= wr_data[LIMIT_W-1:0];
				CFG_DEADBAND: cfg_q.deadband <= wr_data[DB_W-1:0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/lcsr_seq.sv */
// ----------------------------------------------------------------------------
// lcsr_seq
// Read sequencer: poll, bit clocking, gain pulse, and net count (stage 1).
// ----------------------------------------------------------------------------
`default_nettype none

module lcsr_seq
	import lcsr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_fire,
	input  wire logic start_req,
	input  wire logic data_pin,
	input  wire cfg_t cfg,
	output logic      v_s1,
	output s1_t       res_s1
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WAIT,
		PH_CLK_HI,
		PH_CLK_LO,
		PH_GAIN_HI,
		PH_GAIN_LO
	} phase_t;

	phase_t                  phase_q, phase_d;
	logic [POLL_W-1:0]       poll_q, poll_d, poll_inc;
	logic [DIV_W-1:0]        div_q, div_d;
	logic [BIT_W-1:0]        bit_q, bit_d, bit_inc;
	logic [RAW_W-1:0]        shift_q, shift_d;
	logic signed [RAW_W-1:0] raw_q, raw_d, shift_raw;
	logic                    clk_pin, done, tmo;
	logic signed [NET_W-1:0] net_full, db_neg, net_adj;
	s1_t                     res_d;

	assign poll_inc  = poll_q + POLL_W'(1);
	assign bit_inc   = bit_q + BIT_W'(1);
	assign shift_raw = $signed(shift_q << SEXT_SH) >>> SEXT_SH;

	// Next state for one tick
	always_comb begin
		phase_d = phase_q;
		poll_d  = poll_q;
		div_d   = div_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		raw_d   = raw_q;
		clk_pin = 1'b0;
		done    = 1'b0;
		tmo     = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (start_req) begin
					phase_d = PH_WAIT;
					poll_d  = '0;
					div_d   = '0;
				end
			end
			PH_WAIT: begin
				if (div_q != '0) begin
					div_d = div_q - DIV_W'(1);
				end else if (!data_pin) begin
					phase_d = PH_CLK_HI;
					bit_d   = '0;
					shift_d = '0;
					clk_pin = 1'b1;
				end else begin
					poll_d = poll_inc;
					// limit of zero behaves as one
					if (poll_inc >= cfg.limit || poll_inc == '0) begin
						phase_d = PH_IDLE;
						raw_d   = '0;
						done    = 1'b1;
						tmo     = 1'b1;
					end else begin
						div_d = DIV_W'(POLL_TICKS - 1);
					end
				end
			end
			PH_CLK_HI: phase_d = PH_CLK_LO;
			PH_CLK_LO: begin
				shift_d = {shift_q[RAW_W-2:0], data_pin};
				bit_d   = bit_inc;
				phase_d = (bit_inc >= BIT_W'(DATA_BITS)) ? PH_GAIN_HI : PH_CLK_HI;
				clk_pin = 1'b1;
			end
			PH_GAIN_HI: phase_d = PH_GAIN_LO;
			PH_GAIN_LO: begin
				phase_d = PH_IDLE;
				raw_d   = shift_raw;
				done    = 1'b1;
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// Net count with negative deadband, clamped to positive
	always_comb begin
		net_full = NET_W'(cfg.tare) - NET_W'(raw_d);
		db_neg   = -$signed({{(NET_W-DB_W){1'b0}}, cfg.deadband});
		net_adj  = (net_full < 0 && net_full > db_neg) ? '0 : net_full;
		res_d.clock_pin = clk_pin;
		res_d.busy      = (phase_d != PH_IDLE);
		res_d.done      = done;
		res_d.timed_out = tmo;
		res_d.raw       = raw_d;
		res_d.net       = (net_adj > 0) ? net_adj[RAW_W-1:0] : '0;
	end

	// State and stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			poll_q  <= '0;
			div_q   <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			raw_q   <= '0;
			v_s1    <= 1'b0;
			res_s1  <= '0;
		end else begin
			if (in_fire) begin
				phase_q <= phase_d;
				poll_q  <= poll_d;
				div_q   <= div_d;
				bit_q   <= bit_d;
				shift_q <= shift_d;
				raw_q   <= raw_d;
			end
			if (en) begin
				v_s1   <= in_fire;
				res_s1 <= res_d;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/lcsr_scale.sv */
// ----------------------------------------------------------------------------
// lcsr_scale
// Gain multiply, saturation and output register (stage 2).
// ----------------------------------------------------------------------------
`default_nettype none

module lcsr_scale
	import lcsr_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    v_s1,
	input  wire s1_t                     res_s1,
	input  wire logic [GAIN_W-1:0]       gain,
	output logic                         out_valid,
	output logic                         clock_pin,
	output logic                         busy_res,
	output logic                         done_res,
	output logic                         timed_out,
	output logic signed [RAW_W-1:0]      raw_count,
	output logic [WEIGHT_W-1:0]          weight_code
);

	localparam logic [RAW_W-1:0] WEIGHT_MAX = RAW_W'((2 ** WEIGHT_W) - 1);

	logic [PROD_W-1:0]   prod;
	logic [RAW_W-1:0]    scaled;
	logic [WEIGHT_W-1:0] weight_new, last_weight_q, weight_d;

	// Q0.32 scaling, truncate, saturate
	assign prod       = PROD_W'(res_s1.net) * PROD_W'(gain);
	assign scaled     = prod[PROD_W-1:GAIN_W];
	assign weight_new = (scaled > WEIGHT_MAX) ? '1 : scaled[WEIGHT_W-1:0];
	assign weight_d   = res_s1.done ? weight_new : last_weight_q;

	// Held weight and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_weight_q <= '0;
			out_valid     <= 1'b0;
			clock_pin     <= 1'b0;
			busy_res      <= 1'b0;
			done_res      <= 1'b0;
			timed_out     <= 1'b0;
			raw_count     <= '0;
			weight_code   <= '0;
		end else if (en) begin
			out_valid <= v_s1;
			if (v_s1) begin
				last_weight_q <= weight_d;
				clock_pin     <= res_s1.clock_pin;
				busy_res      <= res_s1.busy;
				done_res      <= res_s1.done;
				timed_out     <= res_s1.timed_out;
				raw_count     <= res_s1.raw;
				weight_code   <= weight_d;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/lcsr_checker.sv */
// ----------------------------------------------------------------------------
// lcsr_checker
// Port-level checks for the load-cell serial reader, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsr_checker
	import lcsr_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic                  clock_pin,
	input wire logic                  busy_res,
	input wire logic                  done_res,
	input wire logic                  timed_out,
	input wire logic [RAW_W-1:0]      raw_count,
	input wire logic [WEIGHT_W-1:0]   weight_code
);

	// A finished read is never reported as busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done beat shows busy");

	// Timeout only with done, and reports a zero count
	a_timeout_raw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timed_out |-> done_res && raw_count == '0)
		else $error("timeout beat malformed");

	// Serial clock is only driven during a read
	a_clk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clock_pin |-> busy_res)
		else $error("clock pulse outside a read");

	// Stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(weight_code)
			&& $stable(raw_count) && $stable(done_res))
		else $error("stalled result beat changed");

endmodule

bind load_cell_serial_reader lcsr_checker u_lcsr_checker (.*);

`default_nettype wire
